/* hdl/utf8_text_cursor_layout_top_defines.svh */
// Assertion macros used by the checker file of the text cursor block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UTF8_TEXT_CURSOR_LAYOUT_TOP_DEFINES_SVH
`define UTF8_TEXT_CURSOR_LAYOUT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTCL_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("utcl check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define UTCL_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("utcl check failed: next-cycle property");

`endif

/* hdl/utcl_pkg.sv */
package utcl_pkg;

	// Function codes of an input word.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TEXT  = 1'b1;

	// Register indexes of the configuration port.
	localparam logic REG_GLYPH_WIDTH  = 1'b0;
	localparam logic REG_GLYPH_HEIGHT = 1'b1;

	localparam int ADDR_W = 3;

	localparam logic [7:0] GLYPH_W_RESET = 8'd8;
	localparam logic [7:0] GLYPH_H_RESET = 8'd16;

	// Tab spacing is four glyph widths, so it needs two bits more than a width.
	localparam int TAB_BITS = 10;

	// UTF-8 lead byte patterns.
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;

	// Control code points that move the cursor without drawing.
	localparam logic [20:0] CP_TAB = 21'h09;
	localparam logic [20:0] CP_LF  = 21'h0A;
	localparam logic [20:0] CP_CR  = 21'h0D;

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_CODE  = 1'b1
	} cmd_kind_t;

	// One command from the decoder to the cursor unit.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] org_x;
		logic [15:0] org_y;
		logic [31:0] color;
		logic [20:0] cp;
	} cmd_t;

	// Queue status seen by the cursor unit.
	typedef struct packed {
		logic empty;
		cmd_t head;
	} fifo_stat_t;

endpackage

/* hdl/utcl_decoder.sv */
module utcl_decoder import utcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [31:0] ink_color,
	input  logic [7:0]  byte_value,
	input  logic        full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [1:0]  pending_q, pending_n;
	logic [20:0] accum_q, accum_n;
	logic        ended_q, ended_n;
	logic        acc;
	logic [20:0] cont_cp;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;

	// A continuation byte shifts in six payload bits.
	assign cont_cp = {accum_q[14:0], byte_value[5:0]};

	// Classify each accepted word and build the command for the queue.
	always_comb begin
		pending_n      = pending_q;
		accum_n        = accum_q;
		ended_n        = ended_q;
		push           = 1'b0;
		push_cmd.kind  = CMD_CODE;
		push_cmd.org_x = origin_x;
		push_cmd.org_y = origin_y;
		push_cmd.color = ink_color;
		push_cmd.cp    = '0;
		if (acc) begin
			if (func == FUNC_START) begin
				pending_n     = 2'd0;
				accum_n       = '0;
				ended_n       = 1'b0;
				push          = 1'b1;
				push_cmd.kind = CMD_START;
			end else if (!ended_q) begin
				if (pending_q != 2'd0) begin
					accum_n   = cont_cp;
					pending_n = pending_q - 2'd1;
					if (pending_q == 2'd1) begin
						push        = 1'b1;
						push_cmd.cp = cont_cp;
					end
				end else if (byte_value == 8'd0) begin
					ended_n = 1'b1;
				end else if ((byte_value & LEAD4_MASK) == LEAD4_CODE) begin
					accum_n   = {18'd0, byte_value[2:0]};
					pending_n = 2'd3;
				end else if ((byte_value & LEAD3_MASK) == LEAD3_CODE) begin
					accum_n   = {17'd0, byte_value[3:0]};
					pending_n = 2'd2;
				end else if ((byte_value & LEAD2_MASK) == LEAD2_CODE) begin
					accum_n   = {16'd0, byte_value[4:0]};
					pending_n = 2'd1;
				end else begin
					push        = 1'b1;
					push_cmd.cp = {14'd0, byte_value[6:0]};
				end
			end
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			accum_q   <= '0;
			ended_q   <= 1'b1;
		end else begin
			pending_q <= pending_n;
			accum_q   <= accum_n;
			ended_q   <= ended_n;
		end
	end

endmodule

/* hdl/utcl_cmd_fifo.sv */
module utcl_cmd_fifo import utcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	output logic       full,
	input  logic       pop,
	output fifo_stat_t stat
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !stat.empty;

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/utcl_cursor.sv */
module utcl_cursor import utcl_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  glyph_width,
	input  logic [7:0]  glyph_height,
	input  fifo_stat_t  stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [20:0] code_point,
	output logic [31:0] draw_color
);

	localparam int CW    = COORD_BITS;
	localparam int CNT_W = $clog2(CW);
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_TAB = 2'b10
	} back_state_t;

	back_state_t         state_q, state_n;
	logic [CW-1:0]       start_x_q, start_x_n;
	logic [CW-1:0]       start_y_q, start_y_n;
	logic [CW-1:0]       cur_x_q, cur_x_n;
	logic [CW-1:0]       cur_y_q, cur_y_n;
	logic [31:0]         pen_q, pen_n;
	logic [CW-1:0]       div_q, div_n;
	logic [TAB_BITS-1:0] rem_q, rem_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic                out_valid_q, out_valid_n;
	logic                load_out;
	logic [15:0]         pos_x_q, pos_y_q;
	logic [20:0]         cp_q;
	logic [31:0]         color_q;

	logic [TAB_BITS-1:0] tab;
	logic [TAB_BITS-1:0] gw_ext;
	logic [TAB_BITS-1:0] gh_ext;
	logic                out_free;
	logic [CW+15:0]      org_x_ext;
	logic [CW+15:0]      org_y_ext;
	logic [CW+15:0]      px_ext;
	logic [CW+15:0]      py_ext;
	logic [TAB_BITS:0]   rem_sh;
	logic [TAB_BITS-1:0] rem_step;

	// Saturating add of a small step to a coordinate.
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
			input logic [TAB_BITS-1:0] b);
		logic [CW+TAB_BITS-1:0] s;
		s = {{TAB_BITS{1'b0}}, a} + {{CW{1'b0}}, b};
		return (s > {{TAB_BITS{1'b0}}, CMAX}) ? CMAX : s[CW-1:0];
	endfunction

	assign tab       = {glyph_width, 2'b00};
	assign gw_ext    = {2'b00, glyph_width};
	assign gh_ext    = {2'b00, glyph_height};
	assign out_free  = !out_valid_q || out_ready;
	assign org_x_ext = {{CW{1'b0}}, stat.head.org_x};
	assign org_y_ext = {{CW{1'b0}}, stat.head.org_y};
	assign px_ext    = {16'd0, cur_x_q};
	assign py_ext    = {16'd0, cur_y_q};

	// One restoring step of the tab remainder, one distance bit per cycle.
	assign rem_sh   = {rem_q, div_q[CW-1]};
	assign rem_step = (rem_sh >= {1'b0, tab}) ? TAB_BITS'(rem_sh - {1'b0, tab})
		: rem_sh[TAB_BITS-1:0];

	// Command execution and cursor update.
	always_comb begin
		state_n     = state_q;
		start_x_n   = start_x_q;
		start_y_n   = start_y_q;
		cur_x_n     = cur_x_q;
		cur_y_n     = cur_y_q;
		pen_n       = pen_q;
		div_n       = div_q;
		rem_n       = rem_q;
		cnt_n       = cnt_q;
		pop         = 1'b0;
		load_out    = 1'b0;
		out_valid_n = out_valid_q && !out_ready;
		case (state_q)
			ST_RUN: begin
				if (!stat.empty) begin
					case (stat.head.kind)
						CMD_START: begin
							pop       = 1'b1;
							start_x_n = org_x_ext[CW-1:0];
							start_y_n = org_y_ext[CW-1:0];
							cur_x_n   = org_x_ext[CW-1:0];
							cur_y_n   = org_y_ext[CW-1:0];
							pen_n     = stat.head.color;
						end
						CMD_CODE: begin
							case (stat.head.cp)
								CP_LF: begin
									pop     = 1'b1;
									cur_y_n = sat_add(cur_y_q, gh_ext);
									cur_x_n = start_x_q;
								end
								CP_CR: begin
									pop     = 1'b1;
									cur_x_n = start_x_q;
								end
								CP_TAB: begin
									pop = 1'b1;
									if (tab != '0 && cur_x_q >= start_x_q) begin
										div_n   = cur_x_q - start_x_q;
										rem_n   = '0;
										cnt_n   = CNT_W'(CW - 1);
										state_n = ST_TAB;
									end
								end
								default: begin
									if (out_free) begin
										pop         = 1'b1;
										load_out    = 1'b1;
										out_valid_n = 1'b1;
										cur_x_n     = sat_add(cur_x_q, gw_ext);
									end
								end
							endcase
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_TAB: begin
				rem_n = rem_step;
				div_n = {div_q[CW-2:0], 1'b0};
				cnt_n = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					cur_x_n = sat_add(cur_x_q, tab - rem_step);
					state_n = ST_RUN;
				end
			end
			default: begin
				state_n = ST_RUN;
			end
		endcase
	end

	// Control and cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			start_x_q   <= '0;
			start_y_q   <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			pen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			start_x_q   <= start_x_n;
			start_y_q   <= start_y_n;
			cur_x_q     <= cur_x_n;
			cur_y_q     <= cur_y_n;
			pen_q       <= pen_n;
			out_valid_q <= out_valid_n;
		end
	end

	// Remainder unit and output word registers.
	always_ff @(posedge clk) begin
		div_q <= div_n;
		rem_q <= rem_n;
		cnt_q <= cnt_n;
		if (load_out) begin
			pos_x_q <= px_ext[15:0];
			pos_y_q <= py_ext[15:0];
			cp_q    <= stat.head.cp;
			color_q <= pen_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign code_point = cp_q;
	assign draw_color = color_q;

endmodule

/* hdl/utf8_text_cursor_layout_top.sv */
// A drawn glyph goes through the command queue into the output register.
// One byte is taken per cycle while the command queue is not full; a drawn
// word leaves each cycle it is taken. A tab holds the cursor unit in its
// bit-serial remainder unit; a two-word queue lets input continue meanwhile.
// Reset (arst_n low, asynchronous) clears the queue, cursor and output valid,
// and sets glyph width 8, height 16; no string is active until a start word.
module utf8_text_cursor_layout_top import utcl_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [15:0]       origin_x,
	input  logic [15:0]       origin_y,
	input  logic [31:0]       ink_color,
	input  logic [7:0]        byte_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       pos_x,
	output logic [15:0]       pos_y,
	output logic [20:0]       code_point,
	output logic [31:0]       draw_color
);

	logic [7:0] glyph_width_q;
	logic [7:0] glyph_height_q;
	logic       reg_sel;
	logic       cfg_wr;
	logic       push;
	cmd_t       push_cmd;
	logic       full;
	logic       pop;
	fifo_stat_t stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= GLYPH_W_RESET;
			glyph_height_q <= GLYPH_H_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_GLYPH_WIDTH) begin
				glyph_width_q <= pwdata[7:0];
			end else begin
				glyph_height_q <= pwdata[7:0];
			end
		end
	end

	// Register read back.
	always_comb begin
		case (reg_sel)
			REG_GLYPH_WIDTH:  prdata = {24'd0, glyph_width_q};
			REG_GLYPH_HEIGHT: prdata = {24'd0, glyph_height_q};
			default:          prdata = '0;
		endcase
	end

	utcl_decoder u_decoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.ink_color  (ink_color),
		.byte_value (byte_value),
		.full       (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	utcl_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.stat     (stat)
	);

	utcl_cursor #(
		.COORD_BITS (COORD_BITS)
	) u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.glyph_width  (glyph_width_q),
		.glyph_height (glyph_height_q),
		.stat         (stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.code_point   (code_point),
		.draw_color   (draw_color)
	);

endmodule

/* hdl/utcl_checker.sv */
`include "utf8_text_cursor_layout_top_defines.svh"

module utcl_checker import utcl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              out_valid,
	input logic              out_ready,
	input logic [15:0]       pos_x,
	input logic [15:0]       pos_y,
	input logic [20:0]       code_point,
	input logic [31:0]       draw_color
);

	logic        cfg_wr;
	logic        rd_after_wr;
	logic        wr_seen_q;
	logic        wr_sel_q;
	logic [7:0]  wr_data_q;
	logic [84:0] out_word;

	assign cfg_wr      = psel && penable && pwrite;
	assign rd_after_wr = wr_seen_q && psel && !pwrite && (paddr[2] == wr_sel_q);
	assign out_word    = {pos_x, pos_y, code_point, draw_color};

	// The last register write, kept for the read-back check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_seen_q <= 1'b0;
			wr_sel_q  <= 1'b0;
			wr_data_q <= '0;
		end else begin
			wr_seen_q <= cfg_wr;
			wr_sel_q  <= paddr[2];
			wr_data_q <= pwdata[7:0];
		end
	end

	// A stalled result word stays offered.
	`UTCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// A stalled result word keeps its payload.
	`UTCL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

	// A register read right after a write to it returns the written byte.
	`UTCL_ASSERT_NOW(a_cfg_readback, rd_after_wr, prdata == {24'd0, wr_data_q})

	// No result word is offered on the first edge after reset release.
	`UTCL_ASSERT_NOW(a_reset_idle, $rose(arst_n), !out_valid)

endmodule

bind utf8_text_cursor_layout_top utcl_checker u_utcl_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import utcl_pkg::*;

	localparam int COORD_BITS = 16;
	// Cycles with no word moving on any port before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Enough for a tab in the remainder unit and two more queued behind it, plus the pipeline.
	localparam int QUIET_CYCLES = 3 * (COORD_BITS + 1) + 16;
	localparam int WORDS_PER_PHASE = 150;

	// One glyph draw command as it leaves the block.
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [20:0] cp;
		logic [31:0] color;
	} glyph_t;

	// Text cursor predictor and the queue of glyphs it expects to see drawn.
	class glyph_scoreboard;
		logic [7:0]  glyph_w = GLYPH_W_RESET;
		logic [7:0]  glyph_h = GLYPH_H_RESET;
		logic [1:0]  bytes_left = '0;
		logic [20:0] cp_accum = '0;
		logic [15:0] cur_x = '0;
		logic [15:0] cur_y = '0;
		logic [15:0] org_x = '0;
		logic [15:0] org_y = '0;
		logic [31:0] pen = '0;
		logic        ended = 1'b1;
		glyph_t      expected_glyphs[$];
		int          errors = 0;

		function int pending();
			return expected_glyphs.size();
		endfunction

		function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = a + b;
			return s[16] ? 16'hFFFF : s[15:0];
		endfunction

		// Move the cursor for one decoded code point, queueing a glyph if it draws.
		function void place(logic [20:0] cp);
			logic [9:0] tab_step;
			glyph_t g;
			tab_step = {glyph_w, 2'b00};
			case (cp)
				CP_LF: begin
					cur_y = sat_add(cur_y, {8'd0, glyph_h});
					cur_x = org_x;
				end
				CP_CR: cur_x = org_x;
				CP_TAB: begin
					if (tab_step != 0 && cur_x >= org_x)
						cur_x = sat_add(cur_x, tab_step - ((cur_x - org_x) % tab_step));
				end
				default: begin
					g.x = cur_x;
					g.y = cur_y;
					g.cp = cp;
					g.color = pen;
					expected_glyphs.push_back(g);
					cur_x = sat_add(cur_x, {8'd0, glyph_w});
				end
			endcase
		endfunction

		// Called for every word the block accepts.
		function void note_word(logic f, logic [15:0] ox, logic [15:0] oy,
				logic [31:0] col, logic [7:0] b);
			if (f == FUNC_START) begin
				org_x = ox;
				org_y = oy;
				cur_x = ox;
				cur_y = oy;
				pen = col;
				bytes_left = '0;
				cp_accum = '0;
				ended = 1'b0;
				return;
			end
			if (ended)
				return;
			// Continuation bytes contribute six bits each, unchecked.
			if (bytes_left != 0) begin
				cp_accum = {cp_accum[14:0], b[5:0]};
				bytes_left--;
				if (bytes_left == 0)
					place(cp_accum);
				return;
			end
			if (b == 8'h00) begin
				ended = 1'b1;
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				cp_accum = {18'd0, b[2:0]};
				bytes_left = 2'd3;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				cp_accum = {17'd0, b[3:0]};
				bytes_left = 2'd2;
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				cp_accum = {16'd0, b[4:0]};
				bytes_left = 2'd1;
			end else begin
				place({14'd0, b[6:0]});
			end
		endfunction

		// Called for every glyph the block hands over.
		function void check_glyph(logic [15:0] x, logic [15:0] y, logic [20:0] cp,
				logic [31:0] col);
			glyph_t want;
			if (expected_glyphs.size() == 0) begin
				$display("%0t: unexpected glyph: expected none, actual x=%h y=%h cp=%h color=%h",
					$time, x, y, cp, col);
				errors++;
				return;
			end
			want = expected_glyphs.pop_front();
			if (want.x !== x) begin
				$display("%0t: pos_x mismatch: expected %h, actual %h", $time, want.x, x);
				errors++;
			end
			if (want.y !== y) begin
				$display("%0t: pos_y mismatch: expected %h, actual %h", $time, want.y, y);
				errors++;
			end
			if (want.cp !== cp) begin
				$display("%0t: code_point mismatch: expected %h, actual %h", $time, want.cp, cp);
				errors++;
			end
			if (want.color !== col) begin
				$display("%0t: draw_color mismatch: expected %h, actual %h", $time, want.color,
					col);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic [15:0]       origin_x;
	logic [15:0]       origin_y;
	logic [31:0]       ink_color;
	logic [7:0]        byte_value;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [15:0]       pos_x;
	logic [15:0]       pos_y;
	logic [20:0]       code_point;
	logic [31:0]       draw_color;

	glyph_scoreboard sb;
	int src_idle = 0;
	int sink_idle = 0;
	int words_sent = 0;
	int stall_cycles = 0;

	utf8_text_cursor_layout_top #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.ink_color(ink_color),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.code_point(code_point),
		.draw_color(draw_color)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random with the current idle share.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_idle);
	end

	// Check results before noting inputs: a word accepted now cannot cause a glyph now.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_glyph(pos_x, pos_y, code_point, draw_color);
		if (arst_n && in_valid && in_ready)
			sb.note_word(func, origin_x, origin_y, ink_color, byte_value);
		if ((out_valid && out_ready) || (in_valid && in_ready) ||
				(psel && penable && pwrite && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one word; valid stays high from the previous word when no gap is drawn.
	task automatic send_word(input logic f, input logic [15:0] ox, input logic [15:0] oy,
			input logic [31:0] col, input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		origin_x <= ox;
		origin_y <= oy;
		ink_color <= col;
		byte_value <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_text(input logic [7:0] b);
		send_word(FUNC_TEXT, 16'($urandom), 16'($urandom), $urandom, b);
		words_sent++;
	endtask

	task automatic send_start(input logic [15:0] ox, input logic [15:0] oy,
			input logic [31:0] col);
		send_word(FUNC_START, ox, oy, col, 8'($urandom));
		words_sent++;
	endtask

	// Hold the sender until every glyph has come out and a tab could have finished.
	task automatic wait_for_glyphs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES)
			@(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the data at the access edge.
	task automatic reg_write(input logic idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_GLYPH_WIDTH)
			sb.glyph_w = value;
		else
			sb.glyph_h = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// A multibyte sequence with random payload; sometimes cut short or with odd followers.
	task automatic send_sequence(input int extra);
		logic [7:0] lead;
		int count;
		case (extra)
			1: lead = {3'b110, 5'($urandom)};
			2: lead = {4'b1110, 4'($urandom)};
			default: lead = {5'b11110, 3'($urandom)};
		endcase
		count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, extra - 1) : extra;
		send_text(lead);
		repeat (count)
			send_text(($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)});
	endtask

	// One string: start word, a run of characters, usually a terminator.
	task automatic send_string();
		logic [15:0] ox;
		logic [15:0] oy;
		int kind;
		ox = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 700)) : 16'($urandom);
		oy = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 700)) : 16'($urandom);
		send_start(ox, oy, $urandom);
		repeat ($urandom_range(1, 12)) begin
			kind = $urandom_range(0, 99);
			if (kind < 42)
				send_text(8'($urandom_range(8'h20, 8'h7E)));
			else if (kind < 48)
				send_text(CP_TAB[7:0]);
			else if (kind < 52)
				send_text(CP_LF[7:0]);
			else if (kind < 55)
				send_text(CP_CR[7:0]);
			else if (kind < 67)
				send_sequence(1);
			else if (kind < 77)
				send_sequence(2);
			else if (kind < 85)
				send_sequence(3);
			else if (kind < 97)
				send_text(8'($urandom_range(1, 255)));
			else
				send_text(8'h00);
		end
		if ($urandom_range(0, 3) != 0) begin
			send_text(8'h00);
			// A trailing word after the end is ignored by the block.
			if ($urandom_range(0, 3) == 0) begin
				send_text(8'($urandom));
				words_sent--;
			end
		end
	endtask

	initial begin
		int ph;
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		func <= FUNC_START;
		origin_x <= '0;
		origin_y <= '0;
		ink_color <= '0;
		byte_value <= '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the reset glyph size.
		src_idle = 20;
		sink_idle = 54;
		send_text(8'h41);
		send_start(16'h0000, 16'h0000, 32'hFFFF_FFFF);
		send_text(8'h41);
		send_text(CP_TAB[7:0]);
		send_text(CP_CR[7:0]);
		send_text(CP_LF[7:0]);
		// Largest four-byte code point.
		send_text(8'hF7);
		send_text(8'hBF);
		send_text(8'hBF);
		send_text(8'hBF);
		// A zero continuation byte does not end the string.
		send_text(8'hC2);
		send_text(8'h00);
		// A stray continuation byte and an invalid byte are masked to seven bits.
		send_text(8'h80);
		send_text(8'hFF);
		// A start word drops the half-decoded sequence.
		send_text(8'hE2);
		send_start(16'hFFF0, 16'hFFF8, 32'h0000_0000);
		// Both coordinates saturate here.
		send_text(8'h41);
		send_text(CP_TAB[7:0]);
		send_text(CP_LF[7:0]);
		send_text(8'h41);
		// End of string, then an ignored word.
		send_text(8'h00);
		send_text(8'h41);

		// Random strings under three glyph sizes and three idling patterns.
		for (ph = 0; ph < 3; ph++) begin
			wait_for_glyphs();
			case (ph)
				0: begin
					reg_write(REG_GLYPH_WIDTH, 8'd1);
					reg_write(REG_GLYPH_HEIGHT, 8'd1);
					src_idle = 20;
					sink_idle = 54;
				end
				1: begin
					reg_write(REG_GLYPH_WIDTH, 8'd255);
					reg_write(REG_GLYPH_HEIGHT, 8'd255);
					src_idle = 54;
					sink_idle = 20;
				end
				default: begin
					reg_write(REG_GLYPH_WIDTH, 8'($urandom_range(1, 255)));
					reg_write(REG_GLYPH_HEIGHT, 8'($urandom_range(1, 255)));
					src_idle = 0;
					sink_idle = 0;
				end
			endcase
			words_sent = 0;
			while (words_sent < WORDS_PER_PHASE)
				send_string();
		end

		wait_for_glyphs();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/utcl_pkg.sv
hdl/utcl_decoder.sv
hdl/utcl_cmd_fifo.sv
hdl/utcl_cursor.sv
hdl/utf8_text_cursor_layout_top.sv
hdl/utcl_checker.sv
tb/sv/tb.sv
